// ===== hw/rtl/opr_pkg.sv =====
// ----------------------------------------------------------------------------
// opr_pkg
// Shared types, constants and tables of the orbit point rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package opr_pkg;

  // config port
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORBIT_RADIUS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORBIT_SPEED  = 4'd3;

  localparam logic [30:0] RADIUS_RST = 31'd327680;
  localparam logic [30:0] SPEED_RST  = 31'd655;

  // 0.001 rad expressed in turns, scaled by 2^40
  localparam int          TURN_K_W = 28;
  localparam logic [27:0] TURN_K   = 28'd174992711;
  localparam int          PROD_W   = 31 + TURN_K_W;
  localparam int          PH_SHIFT = 8;
  localparam int          DIVD_W   = PROD_W - PH_SHIFT;
  localparam int          CNT_W    = 6;

  // rotation datapath: 33-bit offset plus guard bits, plus headroom for gain
  localparam int GUARD = 8;
  localparam int DX_W  = 33 + GUARD;
  localparam int XW    = 44;
  localparam int RND_W = XW + 1 - GUARD;
  localparam int SUM_W = 38;

  localparam int          GAIN_W      = 32;
  localparam logic [31:0] CORDIC_GAIN = 32'd2608131496;

  typedef struct packed {
    logic        kind;
    logic [31:0] elapsed;
    logic        paused;
  } opr_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x_out;
    logic               pos_y_out;
    logic signed [31:0] pos_z_out;
    logic               zero_time;
  } opr_out_t;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MUL,
    S_DIV,
    S_ROT,
    S_GAIN,
    S_ROUND,
    S_SAT,
    S_EMIT
  } opr_state_t;

  // arctangent of 2^-i in turns, q0.32
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    unique case (idx)
      5'd0:  atan_turn = 32'd536870912;
      5'd1:  atan_turn = 32'd316933406;
      5'd2:  atan_turn = 32'd167458907;
      5'd3:  atan_turn = 32'd85004756;
      5'd4:  atan_turn = 32'd42667331;
      5'd5:  atan_turn = 32'd21354465;
      5'd6:  atan_turn = 32'd10679838;
      5'd7:  atan_turn = 32'd5340245;
      5'd8:  atan_turn = 32'd2670163;
      5'd9:  atan_turn = 32'd1335087;
      5'd10: atan_turn = 32'd667544;
      5'd11: atan_turn = 32'd333772;
      5'd12: atan_turn = 32'd166886;
      5'd13: atan_turn = 32'd83443;
      5'd14: atan_turn = 32'd41722;
      5'd15: atan_turn = 32'd20861;
      5'd16: atan_turn = 32'd10430;
      5'd17: atan_turn = 32'd5215;
      5'd18: atan_turn = 32'd2608;
      5'd19: atan_turn = 32'd1304;
      5'd20: atan_turn = 32'd652;
      5'd21: atan_turn = 32'd326;
      5'd22: atan_turn = 32'd163;
      5'd23: atan_turn = 32'd81;
      5'd24: atan_turn = 32'd41;
      5'd25: atan_turn = 32'd20;
      5'd26: atan_turn = 32'd10;
      5'd27: atan_turn = 32'd5;
      5'd28: atan_turn = 32'd3;
      5'd29: atan_turn = 32'd1;
      5'd30: atan_turn = 32'd1;
      default: atan_turn = 32'd0;
    endcase
  endfunction

  // clamp to the int32 range
  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > SUM_W'(32'sh7fffffff)) begin
      r = 32'sh7fffffff;
    end else if (v < SUM_W'(32'sh80000000)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/opr_divider.sv =====
// ----------------------------------------------------------------------------
// opr_divider
// Bit-serial restoring divider, one quotient bit per cycle, low 32 bits kept.
// ----------------------------------------------------------------------------
`default_nettype none

module opr_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [opr_pkg::DIVD_W-1:0]  dividend,
  input  wire logic [31:0]                 divisor,
  output logic                             done,
  output logic [31:0]                      quotient
);
  import opr_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] dvd_r;
  logic [31:0]       dsr_r;
  logic [31:0]       rem_r;
  logic [31:0]       quo_r;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;
  logic [31:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[DIVD_W-1]};
    diff    = trial - {1'b0, dsr_r};
    fits    = trial >= {1'b0, dsr_r};
    rem_nxt = fits ? diff[31:0] : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[30:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/opr_cordic.sv =====
// ----------------------------------------------------------------------------
// opr_cordic
// Quarter-turn pre-rotation and iterative CORDIC, one micro-rotation a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module opr_cordic #(
  parameter int STEPS = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [31:0]                      phase,
  input  wire logic signed [opr_pkg::DX_W-1:0]  dx,
  input  wire logic signed [opr_pkg::DX_W-1:0]  dz,
  output logic                                  done,
  output logic signed [opr_pkg::XW-1:0]         x_out,
  output logic signed [opr_pkg::XW-1:0]         z_out
);
  import opr_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] z_r;
  logic signed [31:0]   a_r;

  logic signed [XW-1:0] xe;
  logic signed [XW-1:0] ze;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] z0;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] zs;
  logic signed [31:0]   at;

  always_comb begin
    xe = XW'(dx);
    ze = XW'(dz);
    unique case (phase[31:30])
      2'd0: begin x0 = xe;  z0 = ze;  end
      2'd1: begin x0 = -ze; z0 = xe;  end
      2'd2: begin x0 = -xe; z0 = -ze; end
      2'd3: begin x0 = ze;  z0 = -xe; end
    endcase
    xs = x_r >>> cnt_r[4:0];
    zs = z_r >>> cnt_r[4:0];
    at = $signed(atan_turn(cnt_r[4:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x0;
      z_r <= z0;
      a_r <= $signed({2'b00, phase[29:0]});
    end else if (busy_r) begin
      if (!a_r[31]) begin
        x_r <= x_r - zs;
        z_r <= z_r + xs;
        a_r <= a_r - at;
      end else begin
        x_r <= x_r + zs;
        z_r <= z_r - xs;
        a_r <= a_r + at;
      end
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign z_out = z_r;

endmodule

`default_nettype wire

// ===== hw/rtl/opr_gain.sv =====
// ----------------------------------------------------------------------------
// opr_gain
// Serial shift-add multiply by the CORDIC gain, one gain bit per cycle,
// magnitude truncated and the sign put back in a final step.
// ----------------------------------------------------------------------------
`default_nettype none

module opr_gain (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [opr_pkg::XW-1:0] v,
  output logic                               done,
  output logic signed [opr_pkg::XW-1:0]      res
);
  import opr_pkg::*;

  logic             busy_r;
  logic             fix_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [GAIN_W-1:0] g_r;
  logic [XW-1:0]    mag_r;
  logic [XW-1:0]    acc_r;
  logic             neg_r;
  logic signed [XW-1:0] res_r;

  logic [XW:0] sum;

  // right shift after each add keeps the running floor exact
  assign sum = {1'b0, acc_r} + (g_r[0] ? {1'b0, mag_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fix_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(GAIN_W - 1)) begin
          busy_r <= 1'b0;
          fix_r  <= 1'b1;
        end
      end else if (fix_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= v[XW-1];
      mag_r <= v[XW-1] ? -v : v;
      acc_r <= '0;
      g_r   <= CORDIC_GAIN;
    end else if (busy_r) begin
      acc_r <= sum[XW:1];
      g_r   <= {1'b0, g_r[GAIN_W-1:1]};
    end else if (fix_r) begin
      res_r <= neg_r ? -$signed(acc_r) : $signed(acc_r);
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/orbit_point_rotator_core.sv =====
// ----------------------------------------------------------------------------
// orbit_point_rotator_core
// Orbiting body position: restart, hold, or rotate about the center by
// the angle 0.001 * orbit_speed / elapsed using a serial CORDIC datapath.
// ----------------------------------------------------------------------------
// restart, paused or zero-elapsed items go from S_START straight to S_EMIT, past the datapath
// a rotating tick runs multiply, divide, CORDIC, gain, round and saturate before its result
// one item at a time, the next transfer only once the result is loaded and S_IDLE is back
// the bit-serial divider, the CORDIC loop and the serial gain multiply set the rotating time
// reset: synchronous, clears control and position and loads the config reset values at once
`default_nettype none

module orbit_point_rotator_core #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // item channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire opr_pkg::opr_in_t                in_data,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output opr_pkg::opr_out_t                    out_data,
  // config write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [opr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_data
);
  import opr_pkg::*;

  // config registers
  logic signed [31:0] cx_r;
  logic signed [31:0] cz_r;
  logic [30:0]        radius_r;
  logic [30:0]        speed_r;

  // body position
  logic signed [31:0] bx_r;
  logic signed [31:0] bz_r;

  // sequencer
  opr_state_t state_r;
  opr_state_t state_nxt;
  logic       div_start;
  logic       cor_start;
  logic       gain_start;
  logic       emit;

  // item and working values
  opr_in_t               item_r;
  logic                  zflag_r;
  logic [PROD_W-1:0]     prod_r;
  logic signed [DX_W-1:0] dx_r;
  logic signed [DX_W-1:0] dz_r;
  logic signed [RND_W-1:0] rx_r;
  logic signed [RND_W-1:0] rz_r;

  // result register
  logic     out_valid_r;
  opr_out_t out_data_r;

  // unit handshakes
  logic                 div_done;
  logic [31:0]          phase;
  logic                 cor_done;
  logic signed [XW-1:0] cor_x;
  logic signed [XW-1:0] cor_z;
  logic                 gx_done;
  logic                 gz_done;
  logic signed [XW-1:0] gx_res;
  logic signed [XW-1:0] gz_res;

  // combinational arithmetic
  logic                    tick_go;
  logic signed [SUM_W-1:0] rst_sum;
  logic signed [SUM_W-1:0] res_x_sum;
  logic signed [SUM_W-1:0] res_z_sum;
  logic signed [32:0]      dx_sub;
  logic signed [32:0]      dz_sub;
  logic signed [XW:0]      rnd_x;
  logic signed [XW:0]      rnd_z;

  always_comb begin
    // only a live tick with nonzero elapsed time rotates
    tick_go   = (item_r.kind == KIND_TICK) && (item_r.elapsed != 32'd0) && !item_r.paused;
    rst_sum   = SUM_W'(cx_r) + $signed({7'b0, radius_r});
    res_x_sum = SUM_W'(cx_r) + SUM_W'(rx_r);
    res_z_sum = SUM_W'(cz_r) + SUM_W'(rz_r);
    dx_sub    = 33'(bx_r) - 33'(cx_r);
    dz_sub    = 33'(bz_r) - 33'(cz_r);
    // round half up while dropping the guard bits
    rnd_x     = (XW+1)'(gx_res) + (XW+1)'(128);
    rnd_z     = (XW+1)'(gz_res) + (XW+1)'(128);
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and unit strobes
  always_comb begin
    state_nxt  = state_r;
    div_start  = 1'b0;
    cor_start  = 1'b0;
    gain_start = 1'b0;
    emit       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        state_nxt = tick_go ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          cor_start = 1'b1;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (cor_done) begin
          gain_start = 1'b1;
          state_nxt  = S_GAIN;
        end
      end
      S_GAIN: begin
        if (gx_done && gz_done) state_nxt = S_ROUND;
      end
      S_ROUND: begin
        state_nxt = S_SAT;
      end
      S_SAT: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // wait for the result register to be free or drained this cycle
        if (!out_valid_r || out_ready) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // config writes, always taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cz_r     <= '0;
      radius_r <= RADIUS_RST;
      speed_r  <= SPEED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X:     cx_r     <= $signed(cfg_data);
        REG_CENTER_Z:     cz_r     <= $signed(cfg_data);
        REG_ORBIT_RADIUS: radius_r <= cfg_data[30:0];
        REG_ORBIT_SPEED:  speed_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // body position: restart places it, the saturate step stores the rotation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_r <= '0;
      bz_r <= '0;
    end else if (state_r == S_START && item_r.kind == KIND_RESTART) begin
      bx_r <= sat32(rst_sum);
      bz_r <= '0;
    end else if (state_r == S_SAT) begin
      bx_r <= sat32(res_x_sum);
      bz_r <= sat32(res_z_sum);
    end
  end

  // item latch and working registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (state_r == S_START) begin
      zflag_r <= (item_r.kind == KIND_TICK) && (item_r.elapsed == 32'd0);
      prod_r  <= PROD_W'(speed_r) * PROD_W'(TURN_K);
      dx_r    <= $signed({dx_sub, {GUARD{1'b0}}});
      dz_r    <= $signed({dz_sub, {GUARD{1'b0}}});
    end
    if (state_r == S_ROUND) begin
      rx_r <= rnd_x[XW:GUARD];
      rz_r <= rnd_z[XW:GUARD];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.pos_x_out <= bx_r;
      out_data_r.pos_y_out <= 1'b0;
      out_data_r.pos_z_out <= bz_r;
      out_data_r.zero_time <= zflag_r;
    end
  end

  // phase = speed * k / elapsed in turns, low 32 bits wrap one full turn
  opr_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r[PROD_W-1:PH_SHIFT]),
    .divisor  (item_r.elapsed),
    .done     (div_done),
    .quotient (phase)
  );

  opr_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .phase (phase),
    .dx    (dx_r),
    .dz    (dz_r),
    .done  (cor_done),
    .x_out (cor_x),
    .z_out (cor_z)
  );

  // one gain lane per axis, run in lockstep
  opr_gain u_gain_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gain_start),
    .v     (cor_x),
    .done  (gx_done),
    .res   (gx_res)
  );

  opr_gain u_gain_z (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gain_start),
    .v     (cor_z),
    .done  (gz_done),
    .res   (gz_res)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // the divider and the CORDIC report completion only while the sequencer waits on them
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside divide phase");

  a_cor_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == S_ROT))
    else $error("cordic done outside rotate phase");

  a_gain_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    gx_done == gz_done)
    else $error("gain lanes out of step");

  // one item in flight: no second transfer right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // a restart never reports zero elapsed time
  a_restart_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && item_r.kind == KIND_RESTART) |-> !zflag_r)
    else $error("zero_time set on restart");
`endif

endmodule

`default_nettype wire
